### rtl/ack_retry_tracker_defines.svh
// ----------------------------------------------------------------------------
// ack_retry_tracker_defines
// Assertion macros shared by the ack retry tracker modules.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRY_TRACKER_DEFINES_SVH
`define ACK_RETRY_TRACKER_DEFINES_SVH

// same-cycle implication, checked after reset is released
`define ART_ASSERT_IMP(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, checked after reset is released
`define ART_ASSERT_NXT(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Types and constants of the ack retry tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

  localparam int ID_W    = 56;
  localparam int REF_W   = 16;
  localparam int TIME_W  = 32;
  localparam int QOS_W   = 2;
  localparam int RETRY_W = 4;
  localparam int TAG_W   = 16;
  localparam int TO_W    = 16;
  localparam int SLOT_W  = 2;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 16;
  localparam int IN_D_W  = 112;
  localparam int OUT_D_W = 96;

  localparam int MAX_RESULTS = 4;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [REF_W-1:0]   ref_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [QOS_W-1:0]   qos_t;
  typedef logic [RETRY_W-1:0] retry_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [TO_W-1:0]    tout_t;
  typedef logic [SLOT_W-1:0]  slot_out_t;
  typedef logic [1:0]         res_cnt_t;

  typedef enum logic [1:0] {
    FUNC_REG  = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_POLL = 2'd2,
    FUNC_AUTO = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    KIND_TRACKED   = 4'd0,
    KIND_UNTRACKED = 4'd1,
    KIND_REJECTED  = 4'd2,
    KIND_CLEARED   = 4'd3,
    KIND_UNKNOWN   = 4'd4,
    KIND_RESENT    = 4'd5,
    KIND_DROPPED   = 4'd6,
    KIND_ACK_SEND  = 4'd7,
    KIND_ACK_SKIP  = 4'd8
  } kind_t;

  localparam logic [CFG_A_W-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_MAX_RTY = 2'd2;

  localparam tout_t  TIMEOUT_RST = 16'd1000;
  localparam retry_t MAX_RTY_RST = 4'd3;
  localparam qos_t   QOS_ACKED   = 2'd1;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic apply;
  } art_cmd_t;

  typedef struct packed {
    logic in_no_work;
    logic in_immediate;
    logic scan_done;
    logic none_due;
    logic res_last;
  } art_sts_t;

endpackage

`default_nettype wire

### rtl/ack_retry_tracker.sv
// ----------------------------------------------------------------------------
// ack_retry_tracker
// Acknowledgment and retransmission table for qos 1 messages.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel carries one command per transaction: register and send,
//         ack received, poll tick or auto-ack request (in_tuser selects).
//   out_* channel returns the results; out_tlast marks the final result of
//         a command. A poll returns up to four results, a disabled poll or a
//         poll with no timed-out slot returns none.
//   cfg_* writes enable, timeout_ms and max_retries at any idle time.
// Timing: one command at a time. Auto-ack, disabled register and disabled
//   poll skip the scan; register, ack and poll otherwise scan one slot per
//   cycle through the single table read port before issuing results.
// Reset: all slots free, tag counter zero, send path disabled,
//   timeout 1000 ms, max retries 3.
// A stalled receiver holds the result register; the block may take and
//   scan one more command but issues no result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_retry_tracker #(
  parameter int SLOTS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // msg_id[55:0], payload_ref[71:56], now_ms[103:72], qos_level[105:104]
  input  wire logic [art_pkg::IN_D_W-1:0]    in_tdata,
  // func[1:0]
  input  wire logic [1:0]                    in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // slot_index[1:0], out_id[57:2], out_payload_ref[73:58],
  // retry_count[77:74], ack_tag[93:78]
  output logic [art_pkg::OUT_D_W-1:0]        out_tdata,
  // kind[3:0]
  output logic [3:0]                         out_tuser,
  output logic                               out_tlast,
  input  wire logic                          cfg_wr_en,
  input  wire logic [art_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [art_pkg::CFG_D_W-1:0]   cfg_wdata
);

  art_pkg::art_cmd_t  cmd;
  art_pkg::art_sts_t  sts;
  art_pkg::kind_t     res_kind;
  art_pkg::slot_out_t res_slot;
  art_pkg::id_t       res_id;
  art_pkg::ref_t      res_ref;
  art_pkg::retry_t    res_retry;
  art_pkg::tag_t      res_tag;
  logic               res_last;

  art_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  art_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_func        (in_tuser),
    .in_msg_id      (in_tdata[55:0]),
    .in_payload_ref (in_tdata[71:56]),
    .in_now_ms      (in_tdata[103:72]),
    .in_qos_level   (in_tdata[105:104]),
    .cmd            (cmd),
    .sts            (sts),
    .res_kind_r     (res_kind),
    .res_slot_r     (res_slot),
    .res_id_r       (res_id),
    .res_ref_r      (res_ref),
    .res_retry_r    (res_retry),
    .res_tag_r      (res_tag),
    .res_last_r     (res_last)
  );

  assign out_tdata = {2'b00, res_tag, res_retry, res_ref, res_id, res_slot};
  assign out_tuser = res_kind;
  assign out_tlast = res_last;

endmodule

`default_nettype wire

### rtl/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: takes a transaction, walks the slot scan when the command needs one, then issues results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ack_retry_tracker_defines.svh"

module art_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire art_pkg::art_sts_t sts,
  output art_pkg::art_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_tvalid;
    cmd.scan_step = (state_r == S_SCAN);
    cmd.apply     = (state_r == S_APPLY) && !sts.none_due && out_free;

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (sts.in_no_work) begin
            state_nxt = S_IDLE;
          end else if (sts.in_immediate) begin
            state_nxt = S_APPLY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (sts.none_due) begin
          state_nxt = S_IDLE;
        end else if (cmd.apply && sts.res_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // output register frees when taken, reloads on every result
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ART_ASSERT_IMP(a_valid_from_apply, clk, rst_n, $rose(out_valid_r), $past(cmd.apply))
  `ART_ASSERT_NXT(a_no_work_idle, clk, rst_n, cmd.load && sts.in_no_work, state_r == S_IDLE)
  `ART_ASSERT_NXT(a_scan_holds, clk, rst_n, (state_r == S_SCAN) && !sts.scan_done,
                  state_r == S_SCAN)

endmodule

`default_nettype wire

### rtl/art_dp.sv
// ----------------------------------------------------------------------------
// art_dp
// Slot table, configuration registers, scan mask and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ack_retry_tracker_defines.svh"

module art_dp #(
  parameter int SLOTS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [art_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [art_pkg::CFG_D_W-1:0]   cfg_wdata,
  input  wire logic [1:0]                    in_func,
  input  wire art_pkg::id_t                  in_msg_id,
  input  wire art_pkg::ref_t                 in_payload_ref,
  input  wire art_pkg::time_t                in_now_ms,
  input  wire art_pkg::qos_t                 in_qos_level,
  input  wire art_pkg::art_cmd_t             cmd,
  output art_pkg::art_sts_t                  sts,
  output art_pkg::kind_t                     res_kind_r,
  output art_pkg::slot_out_t                 res_slot_r,
  output art_pkg::id_t                       res_id_r,
  output art_pkg::ref_t                      res_ref_r,
  output art_pkg::retry_t                    res_retry_r,
  output art_pkg::tag_t                      res_tag_r,
  output logic                               res_last_r
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // configuration and counters
  logic              enable_r;
  art_pkg::tout_t    timeout_r;
  art_pkg::retry_t   max_rty_r;
  art_pkg::tag_t     ack_cnt_r, ack_cnt_nxt;

  // captured transaction
  art_pkg::func_t    func_r;
  art_pkg::id_t      id_r;
  art_pkg::ref_t     ref_r;
  art_pkg::time_t    now_r;
  art_pkg::qos_t     qos_r;

  // slot table
  logic [SLOTS-1:0]  used_r;
  art_pkg::id_t      slot_id_r    [SLOTS];
  art_pkg::ref_t     slot_ref_r   [SLOTS];
  art_pkg::retry_t   slot_rty_r   [SLOTS];
  art_pkg::time_t    slot_time_r  [SLOTS];

  // scan control
  logic [IdxW-1:0]   idx_r;
  logic [SLOTS-1:0]  mask_r;
  art_pkg::res_cnt_t cnt_r;

  logic [IdxW-1:0]   pick_idx, rd_idx;
  logic              pick_any;
  logic [SLOTS-1:0]  mask_rest;
  art_pkg::id_t      rd_id;
  art_pkg::ref_t     rd_ref;
  art_pkg::retry_t   rd_rty;
  art_pkg::time_t    rd_time;
  art_pkg::time_t    elapsed;
  logic              hit;
  logic              claim, free_slot, bump;
  art_pkg::tag_t     tag_inc;

  art_pkg::kind_t     res_kind_nxt;
  art_pkg::slot_out_t res_slot_nxt;
  art_pkg::id_t       res_id_nxt;
  art_pkg::ref_t      res_ref_nxt;
  art_pkg::retry_t    res_retry_nxt;
  art_pkg::tag_t      res_tag_nxt;

  // lowest pending slot of the scan mask
  always_comb begin
    pick_idx = '0;
    pick_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick_idx = IdxW'(i);
        pick_any = 1'b1;
      end
    end
  end

  assign mask_rest = mask_r & ~(SLOTS'(1) << pick_idx);
  assign rd_idx    = cmd.scan_step ? idx_r : pick_idx;
  assign rd_id     = slot_id_r[rd_idx];
  assign rd_ref    = slot_ref_r[rd_idx];
  assign rd_rty    = slot_rty_r[rd_idx];
  assign rd_time   = slot_time_r[rd_idx];
  assign elapsed   = now_r - rd_time;

  always_comb begin
    case (func_r)
      art_pkg::FUNC_REG:  hit = !used_r[rd_idx];
      art_pkg::FUNC_ACK:  hit = used_r[rd_idx] && (rd_id == id_r);
      art_pkg::FUNC_POLL: hit = used_r[rd_idx] && (elapsed >= art_pkg::time_t'(timeout_r));
      default:            hit = 1'b0;
    endcase
  end

  always_comb begin
    sts              = '0;
    sts.in_no_work   = (art_pkg::func_t'(in_func) == art_pkg::FUNC_POLL) && !enable_r;
    sts.in_immediate = (art_pkg::func_t'(in_func) == art_pkg::FUNC_AUTO) ||
                       ((art_pkg::func_t'(in_func) == art_pkg::FUNC_REG) && !enable_r);
    sts.scan_done    = (idx_r == IdxW'(SLOTS - 1));
    sts.none_due     = (func_r == art_pkg::FUNC_POLL) && !pick_any;
    sts.res_last     = (func_r != art_pkg::FUNC_POLL) || (mask_rest == '0) ||
                       (cnt_r == art_pkg::res_cnt_t'(art_pkg::MAX_RESULTS - 1));
  end

  always_comb begin
    res_kind_nxt  = art_pkg::KIND_ACK_SKIP;
    res_slot_nxt  = '0;
    res_id_nxt    = id_r;
    res_ref_nxt   = '0;
    res_retry_nxt = '0;
    res_tag_nxt   = '0;
    ack_cnt_nxt   = ack_cnt_r;
    claim         = 1'b0;
    free_slot     = 1'b0;
    bump          = 1'b0;
    tag_inc       = ack_cnt_r + art_pkg::tag_t'(1);

    unique case (func_r)
      art_pkg::FUNC_REG: begin
        if (!enable_r) begin
          res_kind_nxt = art_pkg::KIND_REJECTED;
        end else if (!pick_any) begin
          res_kind_nxt = art_pkg::KIND_UNTRACKED;
          res_ref_nxt  = ref_r;
        end else begin
          claim        = 1'b1;
          res_kind_nxt = art_pkg::KIND_TRACKED;
          res_slot_nxt = art_pkg::slot_out_t'(pick_idx);
          res_ref_nxt  = ref_r;
        end
      end
      art_pkg::FUNC_ACK: begin
        if (!pick_any) begin
          res_kind_nxt = art_pkg::KIND_UNKNOWN;
        end else begin
          free_slot     = 1'b1;
          res_kind_nxt  = art_pkg::KIND_CLEARED;
          res_slot_nxt  = art_pkg::slot_out_t'(pick_idx);
          res_retry_nxt = rd_rty;
        end
      end
      art_pkg::FUNC_POLL: begin
        res_id_nxt   = rd_id;
        res_slot_nxt = art_pkg::slot_out_t'(pick_idx);
        if (rd_rty < max_rty_r) begin
          bump          = 1'b1;
          res_kind_nxt  = art_pkg::KIND_RESENT;
          res_ref_nxt   = rd_ref;
          res_retry_nxt = rd_rty + art_pkg::retry_t'(1);
        end else begin
          free_slot     = 1'b1;
          res_kind_nxt  = art_pkg::KIND_DROPPED;
          res_retry_nxt = rd_rty;
        end
      end
      art_pkg::FUNC_AUTO: begin
        if (enable_r && (qos_r == art_pkg::QOS_ACKED)) begin
          // tag counter skips zero on wrap
          ack_cnt_nxt  = (tag_inc == '0) ? art_pkg::tag_t'(1) : tag_inc;
          res_kind_nxt = art_pkg::KIND_ACK_SEND;
          res_tag_nxt  = ack_cnt_nxt;
        end
      end
      default: ;
    endcase

    if (!cmd.apply) begin
      claim       = 1'b0;
      free_slot   = 1'b0;
      bump        = 1'b0;
      ack_cnt_nxt = ack_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      timeout_r <= art_pkg::TIMEOUT_RST;
      max_rty_r <= art_pkg::MAX_RTY_RST;
      ack_cnt_r <= '0;
      used_r    <= '0;
      idx_r     <= '0;
      mask_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          art_pkg::CFG_ENABLE:  enable_r  <= cfg_wdata[0];
          art_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata[art_pkg::TO_W-1:0];
          art_pkg::CFG_MAX_RTY: max_rty_r <= cfg_wdata[art_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end
      ack_cnt_r <= ack_cnt_nxt;
      if (cmd.load) begin
        idx_r  <= '0;
        mask_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.scan_step) begin
        mask_r[idx_r] <= hit;
        if (idx_r != IdxW'(SLOTS - 1)) begin
          idx_r <= idx_r + IdxW'(1);
        end
      end else if (cmd.apply) begin
        mask_r <= mask_rest;
        cnt_r  <= cnt_r + art_pkg::res_cnt_t'(1);
      end
      if (claim) begin
        used_r[pick_idx] <= 1'b1;
      end else if (free_slot) begin
        used_r[pick_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= art_pkg::func_t'(in_func);
      id_r   <= in_msg_id;
      ref_r  <= in_payload_ref;
      now_r  <= in_now_ms;
      qos_r  <= in_qos_level;
    end
    if (claim) begin
      slot_id_r[pick_idx]   <= id_r;
      slot_ref_r[pick_idx]  <= ref_r;
      slot_rty_r[pick_idx]  <= '0;
      slot_time_r[pick_idx] <= now_r;
    end
    if (bump) begin
      slot_rty_r[pick_idx]  <= res_retry_nxt;
      slot_time_r[pick_idx] <= now_r;
    end
    if (cmd.apply) begin
      res_kind_r  <= res_kind_nxt;
      res_slot_r  <= res_slot_nxt;
      res_id_r    <= res_id_nxt;
      res_ref_r   <= res_ref_nxt;
      res_retry_r <= res_retry_nxt;
      res_tag_r   <= res_tag_nxt;
      res_last_r  <= sts.res_last;
    end
  end

  `ART_ASSERT_NXT(a_claim_sets_used, clk, rst_n, claim, used_r[$past(pick_idx)])
  `ART_ASSERT_NXT(a_free_clears_used, clk, rst_n, free_slot, !used_r[$past(pick_idx)])

endmodule

`default_nettype wire
